@@ hdl/reinhard_srgb_pixel_encoder_assert.svh @@
// Assertion macros shared by the encoder RTL.
`ifndef REINHARD_SRGB_PIXEL_ENCODER_ASSERT_SVH
`define REINHARD_SRGB_PIXEL_ENCODER_ASSERT_SVH

// Plain property, sampled on clk_i, ignored while in reset.
`define RSENC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rsenc assertion failed");

// Antecedent holds, so the consequent must hold in the next cycle.
`define RSENC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsenc assertion failed");

`endif

@@ hdl/rsenc_pkg.sv @@
package rsenc_pkg;

  // Fraction bits of radiance and exposure
  localparam int unsigned FracBits   = 16;
  localparam int unsigned RegW       = 24;
  localparam int unsigned RadW       = 32;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned LevelW     = 17;   // Q0.16 level, 0..65536
  localparam int unsigned ProdW      = RadW - 1 + RegW;
  localparam int unsigned WideW      = 73;   // numerator and denominator
  localparam int unsigned DivSteps   = 16;
  localparam int unsigned CodeSteps  = CodeW;
  localparam int unsigned NumStages  = 4 + DivSteps + 1 + CodeSteps;
  localparam int unsigned LinearCodes = 10;

  typedef enum logic [1:0] {
    CfgExposure = 2'd0,
    CfgWhite    = 2'd1
  } cfg_reg_e;

  typedef logic [255:0][LevelW-1:0] thr_tab_t;

  // Exact test: level y (Q0.16) encodes to code k or above
  function automatic logic srgb_reaches(input int unsigned k, input int unsigned y);
    logic [255:0] lhs;
    logic [255:0] rhs;
    logic [63:0]  lin_l;
    logic [63:0]  lin_r;
    lhs = 256'd1;
    rhs = 256'd1;
    lin_l = 64'(y) * 64'd65892;
    lin_r = 64'(2 * k - 1) * 64'd655360;
    if (k <= LinearCodes) begin
      return lin_l >= lin_r;
    end
    for (int i = 0; i < 5; i++) begin
      lhs = lhs * 256'(y);
      rhs = rhs * 256'd65536;
    end
    for (int i = 0; i < 12; i++) begin
      lhs = lhs * 256'd10761;
      rhs = rhs * 256'(40 * k + 541);
    end
    return lhs >= rhs;
  endfunction

  // Smallest level reaching each code, found by bisection at elaboration
  function automatic thr_tab_t build_srgb_thr();
    thr_tab_t    tab;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    tab = '0;
    for (int unsigned k = 1; k < 256; k++) begin
      lo = 0;
      hi = 65536;
      for (int it = 0; it < 18; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (srgb_reaches(k, mid)) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
      end
      tab[k] = LevelW'(lo);
    end
    return tab;
  endfunction

  localparam thr_tab_t SrgbThr = build_srgb_thr();

endpackage

@@ hdl/rsenc_in_if.sv @@
interface rsenc_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       red_radiance;
  logic signed [31:0]       green_radiance;
  logic signed [31:0]       blue_radiance;

  modport source (output valid, red_radiance, green_radiance, blue_radiance, input ready);
  modport sink   (input valid, red_radiance, green_radiance, blue_radiance, output ready);
endinterface

@@ hdl/rsenc_out_if.sv @@
interface rsenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_code;
  logic [7:0] green_code;
  logic [7:0] blue_code;

  modport source (output valid, red_code, green_code, blue_code, input ready);
  modport sink   (input valid, red_code, green_code, blue_code, output ready);
endinterface

@@ hdl/reinhard_srgb_pixel_encoder.sv @@
// Channel  | Dir | Handshake    | Payload
// pix_i    | in  | valid/ready  | red/green/blue_radiance, signed Q15.16
// code_o   | out | valid/ready  | red/green/blue_code, 8 bits
// cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_data_i (24 bits)
//
// One pixel a clock unless a held result stalls the pipeline.
// Each lane holds a 16-stage divider and an 8-stage code search.
// Reset clears the valid bits and loads gain and white level with 1.0.
// A stalled result freezes the whole pipeline; nothing is dropped.
module reinhard_srgb_pixel_encoder import rsenc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rsenc_in_if.sink          pix_i,
  rsenc_out_if.source       code_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [RegW-1:0]   cfg_data_i
);

  logic [RegW-1:0]   gain_q, white_q;
  logic [2*RegW-1:0] w2_q;
  logic [NumStages-1:0] vld_q;
  logic              en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= RegW'(65536);
      white_q <= RegW'(65536);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgExposure) begin
        gain_q <= cfg_data_i;
      end else if (cfg_idx_i == CfgWhite) begin
        white_q <= cfg_data_i;
      end
    end
  end

  // squared white point, follows the register in the next cycle
  always_ff @(posedge clk_i) begin
    w2_q <= (2*RegW)'(white_q) * (2*RegW)'(white_q);
  end

  // pipeline advances unless a result is held
  assign en          = !vld_q[NumStages-1] || code_o.ready;
  assign pix_i.ready = en;
  assign code_o.valid = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], pix_i.valid};
    end
  end

  rsenc_lane u_red (
    .clk_i, .en_i(en), .rad_i(pix_i.red_radiance), .gain_i(gain_q),
    .white_i(white_q), .w2_i(w2_q), .code_o(code_o.red_code)
  );
  rsenc_lane u_green (
    .clk_i, .en_i(en), .rad_i(pix_i.green_radiance), .gain_i(gain_q),
    .white_i(white_q), .w2_i(w2_q), .code_o(code_o.green_code)
  );
  rsenc_lane u_blue (
    .clk_i, .en_i(en), .rad_i(pix_i.blue_radiance), .gain_i(gain_q),
    .white_i(white_q), .w2_i(w2_q), .code_o(code_o.blue_code)
  );

`include "reinhard_srgb_pixel_encoder_assert.svh"

  `RSENC_ASSERT_NEXT(a_enter, pix_i.valid && pix_i.ready, vld_q[0])
  `RSENC_ASSERT(a_free_ready, !vld_q[NumStages-1] |-> pix_i.ready)
  `RSENC_ASSERT_NEXT(a_hold, code_o.valid && !code_o.ready, code_o.valid && vld_q == $past(vld_q))
  `RSENC_ASSERT_NEXT(a_w2, 1'b1, w2_q == (2*RegW)'($past(white_q)) * (2*RegW)'($past(white_q)))

endmodule

@@ hdl/rsenc_lane.sv @@
// One colour channel: exposure, Reinhard curve, sRGB code
module rsenc_lane import rsenc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [RadW-1:0] rad_i,
  input  logic [RegW-1:0]        gain_i,
  input  logic [RegW-1:0]        white_i,
  input  logic [2*RegW-1:0]      w2_i,
  output logic [CodeW-1:0]       code_o
);

  // exposure product, negative and zero radiance give zero
  logic [ProdW-1:0] prod_q;
  logic             rad_pos;
  assign rad_pos = !rad_i[RadW-1] && (rad_i != '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= rad_pos ? ProdW'(rad_i[RadW-2:0]) * ProdW'(gain_i) : '0;
    end
  end

  // exposed value and the at-or-above-white flag
  logic [ProdW-FracBits-1:0] exp_full;
  logic [RegW-1:0]           exp_q;
  logic                      full1_q;
  assign exp_full = prod_q[ProdW-1:FracBits];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q   <= exp_full[RegW-1:0];
      full1_q <= exp_full >= (ProdW-FracBits)'(white_i);
    end
  end

  // partial products of numerator and denominator
  logic [2*RegW-1:0] pa_q, pb_q, pe_q;
  logic [2*RegW:0]   da_q, db_q;
  logic              full2_q;
  logic [RegW:0]     one_plus_e;
  assign one_plus_e = (RegW+1)'(exp_q) + ((RegW+1)'(1) << FracBits);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= (2*RegW)'(exp_q) * (2*RegW)'(w2_i[RegW-1:0]);
      pb_q    <= (2*RegW)'(exp_q) * (2*RegW)'(w2_i[2*RegW-1:RegW]);
      pe_q    <= (2*RegW)'(exp_q) * (2*RegW)'(exp_q);
      da_q    <= (2*RegW+1)'(w2_i[RegW-1:0]) * (2*RegW+1)'(one_plus_e);
      db_q    <= (2*RegW+1)'(w2_i[2*RegW-1:RegW]) * (2*RegW+1)'(one_plus_e);
      full2_q <= full1_q;
    end
  end

  // long division, one quotient bit a stage
  logic [WideW-1:0]    div_rem_q  [DivSteps+1];
  logic [WideW-1:0]    div_den_q  [DivSteps+1];
  logic [DivSteps-1:0] div_quo_q  [DivSteps+1];
  logic                div_full_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_rem_q[0]  <= WideW'(pa_q) + (WideW'(pb_q) << RegW) + (WideW'(pe_q) << FracBits);
      div_den_q[0]  <= WideW'(da_q) + (WideW'(db_q) << RegW);
      div_quo_q[0]  <= '0;
      div_full_q[0] <= full2_q;
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [WideW:0]   twice;
    logic [WideW:0]   diff;
    logic             take;
    logic [WideW-1:0] rem_d;
    always_comb begin
      twice = {div_rem_q[i], 1'b0};
      diff  = twice - {1'b0, div_den_q[i]};
      take  = twice >= {1'b0, div_den_q[i]};
      rem_d = take ? diff[WideW-1:0] : twice[WideW-1:0];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_rem_q[i+1]  <= rem_d;
        div_den_q[i+1]  <= div_den_q[i];
        div_quo_q[i+1]  <= {div_quo_q[i][DivSteps-2:0], take};
        div_full_q[i+1] <= div_full_q[i];
      end
    end
  end

  // code search over the rounding thresholds, one code bit a stage
  logic [LevelW-1:0] srch_y_q [CodeSteps+1];
  logic [CodeW-1:0]  srch_c_q [CodeSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srch_y_q[0] <= div_full_q[DivSteps] ? (LevelW'(1) << DivSteps)
                                          : LevelW'(div_quo_q[DivSteps]);
      srch_c_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < CodeSteps; j++) begin : g_code
    logic [CodeW-1:0] cand;
    assign cand = srch_c_q[j] | (CodeW'(1) << (CodeSteps - 1 - j));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srch_y_q[j+1] <= srch_y_q[j];
        srch_c_q[j+1] <= (srch_y_q[j] >= SrgbThr[cand]) ? cand : srch_c_q[j];
      end
    end
  end

  assign code_o = srch_c_q[CodeSteps];

endmodule
